FILE: rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

	// Block sizes in bytes of the small, mid and large pools.
	localparam int SMALL_BYTES = 32;
	localparam int MID_BYTES   = 48;
	localparam int LARGE_BYTES = 64;

	// Default pool geometry.
	localparam int DEF_SMALL_BLOCKS = 16;
	localparam int DEF_MID_BLOCKS   = 8;
	localparam int DEF_LARGE_BLOCKS = 4;
	localparam int DEF_HEADER_BYTES = 8;

	// Offset inside one pool area stays below 64 blocks of 64 bytes.
	localparam int REL_W = 12;
	// Block index inside one pool stays below 64.
	localparam int LOC_W = 6;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		POOL_SMALL,
		POOL_MID,
		POOL_LARGE
	} pool_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_TOO_LARGE,
		ST_BAD_ADDR
	} status_t;

	typedef struct packed {
		logic        op;
		logic [15:0] req_size;
		logic [31:0] free_addr;
	} item_t;

	typedef struct packed {
		logic [31:0] block_addr;
		status_t     status;
	} result_t;

	// Free list update command.
	typedef struct packed {
		logic  pop;
		logic  push;
		pool_t pool;
	} upd_t;

	// Decoded free address.
	typedef struct packed {
		logic  hit;
		pool_t pool;
	} fdec_t;

endpackage

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator.
// Timing: an accepted request is held in the input register, and its result and
// result strobe are registered in the result register.
// Throughput: one request per cycle; busy stays low, the free lists sit in flops
// so the head read, link read and head write all happen in the same cycle.
// Reset: asynchronous, active low; every pool's free list is rebuilt at once.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator
	import fbpa_pkg::*;
#(
	parameter int POOL_SMALL_BLOCKS = DEF_SMALL_BLOCKS,
	parameter int POOL_MID_BLOCKS   = DEF_MID_BLOCKS,
	parameter int POOL_LARGE_BLOCKS = DEF_LARGE_BLOCKS,
	parameter int HEADER_BYTES      = DEF_HEADER_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire item_t       item,
	output logic             result_valid,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	localparam int TOTAL       = POOL_SMALL_BLOCKS + POOL_MID_BLOCKS + POOL_LARGE_BLOCKS;
	localparam int IW          = $clog2(TOTAL + 1);
	localparam int MID_FIRST   = POOL_SMALL_BLOCKS;
	localparam int LARGE_FIRST = POOL_SMALL_BLOCKS + POOL_MID_BLOCKS;
	localparam int MID_OFF     = POOL_SMALL_BLOCKS * SMALL_BYTES;
	localparam int LARGE_OFF   = MID_OFF + POOL_MID_BLOCKS * MID_BYTES;

	logic [31:0]   area_base_q;
	logic          valid_s1;
	item_t         item_s1;
	logic          result_valid_q;
	result_t       result_q;

	logic          fit;
	pool_t         alloc_pool;
	fdec_t         dec;
	logic [IW-1:0] free_idx;
	upd_t          upd;
	logic [IW-1:0] head;
	logic          head_ok;
	logic [IW-1:0] pool_first;
	logic [IW-1:0] pool_count;
	logic [31:0]   pool_off;
	logic [31:0]   pool_bytes;
	logic [IW-1:0] loc;
	logic [31:0]   alloc_addr;
	result_t       result_d;

	// Every cycle takes a request; the whole job fits in one stage.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_base_q <= '0;
		end else if (cfg_we) begin
			area_base_q <= cfg_wdata;
		end
	end

	// Input register: capture the accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Allocate: pick the first pool whose payload holds the request.
	always_comb begin
		fit        = 1'b1;
		alloc_pool = POOL_SMALL;
		if (item_s1.req_size <= 16'(SMALL_BYTES - HEADER_BYTES)) begin
			alloc_pool = POOL_SMALL;
		end else if (item_s1.req_size <= 16'(MID_BYTES - HEADER_BYTES)) begin
			alloc_pool = POOL_MID;
		end else if (item_s1.req_size <= 16'(LARGE_BYTES - HEADER_BYTES)) begin
			alloc_pool = POOL_LARGE;
		end else begin
			fit = 1'b0;
		end
	end

	// Free: map the payload address back to a block.
	fbpa_free_dec #(
		.POOL_SMALL_BLOCKS(POOL_SMALL_BLOCKS),
		.POOL_MID_BLOCKS  (POOL_MID_BLOCKS),
		.POOL_LARGE_BLOCKS(POOL_LARGE_BLOCKS),
		.HEADER_BYTES     (HEADER_BYTES)
	) u_free_dec (
		.free_addr(item_s1.free_addr),
		.area_base(area_base_q),
		.dec      (dec),
		.idx      (free_idx)
	);

	// Per-pool geometry of the pool being touched.
	always_comb begin
		case (upd.pool)
			POOL_SMALL: begin
				pool_first = '0;
				pool_count = IW'(POOL_SMALL_BLOCKS);
				pool_off   = '0;
				pool_bytes = 32'(SMALL_BYTES);
			end
			POOL_MID: begin
				pool_first = IW'(MID_FIRST);
				pool_count = IW'(POOL_MID_BLOCKS);
				pool_off   = 32'(MID_OFF);
				pool_bytes = 32'(MID_BYTES);
			end
			POOL_LARGE: begin
				pool_first = IW'(LARGE_FIRST);
				pool_count = IW'(POOL_LARGE_BLOCKS);
				pool_off   = 32'(LARGE_OFF);
				pool_bytes = 32'(LARGE_BYTES);
			end
			default: begin
				pool_first = '0;
				pool_count = '0;
				pool_off   = '0;
				pool_bytes = '0;
			end
		endcase
	end

	// A null head (or anything outside the pool) means the pool is empty.
	assign loc     = head - pool_first;
	assign head_ok = (head >= pool_first) && (loc < pool_count);

	always_comb begin
		upd.pool = (item_s1.op == OP_ALLOC) ? alloc_pool : dec.pool;
		upd.pop  = valid_s1 && (item_s1.op == OP_ALLOC) && fit && head_ok;
		upd.push = valid_s1 && (item_s1.op == OP_FREE) && dec.hit;
	end

	fbpa_pool_store #(
		.POOL_SMALL_BLOCKS(POOL_SMALL_BLOCKS),
		.POOL_MID_BLOCKS  (POOL_MID_BLOCKS),
		.POOL_LARGE_BLOCKS(POOL_LARGE_BLOCKS)
	) u_pool_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.push_idx(free_idx),
		.head    (head)
	);

	// Payload address of the popped block; all sums wrap at 32 bits.
	assign alloc_addr = area_base_q + pool_off + 32'(loc) * pool_bytes + 32'(HEADER_BYTES);

	always_comb begin
		result_d.block_addr = '0;
		result_d.status     = ST_OK;
		if (item_s1.op == OP_ALLOC) begin
			if (!fit) begin
				result_d.status = ST_TOO_LARGE;
			end else if (!head_ok) begin
				result_d.status = ST_EMPTY;
			end else begin
				result_d.block_addr = alloc_addr;
			end
		end else if (!dec.hit) begin
			result_d.status = ST_BAD_ADDR;
		end
	end

	// Result register: one strobe per request, no back pressure.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

FILE: rtl/fbpa_free_dec.sv
// Decoder from a freed payload address to its pool and global block index.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_free_dec
	import fbpa_pkg::*;
#(
	parameter int POOL_SMALL_BLOCKS = DEF_SMALL_BLOCKS,
	parameter int POOL_MID_BLOCKS   = DEF_MID_BLOCKS,
	parameter int POOL_LARGE_BLOCKS = DEF_LARGE_BLOCKS,
	parameter int HEADER_BYTES      = DEF_HEADER_BYTES,
	localparam int TOTAL            = POOL_SMALL_BLOCKS + POOL_MID_BLOCKS + POOL_LARGE_BLOCKS,
	localparam int IW               = $clog2(TOTAL + 1)
) (
	input  wire logic [31:0]   free_addr,
	input  wire logic [31:0]   area_base,
	output fdec_t              dec,
	output logic      [IW-1:0] idx
);

	localparam int MID_OFF   = POOL_SMALL_BLOCKS * SMALL_BYTES;
	localparam int LARGE_OFF = MID_OFF + POOL_MID_BLOCKS * MID_BYTES;
	localparam int AREA_END  = LARGE_OFF + POOL_LARGE_BLOCKS * LARGE_BYTES;
	localparam int MID_FIRST   = POOL_SMALL_BLOCKS;
	localparam int LARGE_FIRST = POOL_SMALL_BLOCKS + POOL_MID_BLOCKS;

	logic [31:0]      off;
	logic [31:0]      mid_full;
	logic [31:0]      large_full;
	logic [REL_W-1:0] mid_rel;
	logic [REL_W-1:0] large_rel;
	logic [7:0]       mid_x;
	logic [15:0]      mid_prod;
	logic [7:0]       mid_q;
	logic             mid_aligned;

	assign off        = free_addr - 32'(HEADER_BYTES) - area_base;
	assign mid_full   = off - 32'(MID_OFF);
	assign large_full = off - 32'(LARGE_OFF);
	assign mid_rel    = mid_full[REL_W-1:0];
	assign large_rel  = large_full[REL_W-1:0];

	// Divide by 48: drop four bits, then divide by 3 through a reciprocal.
	assign mid_x       = mid_rel[REL_W-1:4];
	assign mid_prod    = 16'(mid_x) * 16'd171;
	assign mid_q       = 8'(mid_prod >> 9);
	assign mid_aligned = (mid_rel[3:0] == 4'd0) && (mid_x == 8'(mid_q * 8'd3));

	always_comb begin
		dec.hit  = 1'b0;
		dec.pool = POOL_SMALL;
		idx      = '0;
		if (off < 32'(MID_OFF)) begin
			dec.pool = POOL_SMALL;
			dec.hit  = (off[4:0] == 5'd0);
			idx      = IW'(off[5 +: LOC_W]);
		end else if (off < 32'(LARGE_OFF)) begin
			dec.pool = POOL_MID;
			dec.hit  = mid_aligned;
			idx      = IW'(MID_FIRST) + IW'(mid_q[LOC_W-1:0]);
		end else if (off < 32'(AREA_END)) begin
			dec.pool = POOL_LARGE;
			dec.hit  = (large_rel[5:0] == 6'd0);
			idx      = IW'(LARGE_FIRST) + IW'(large_rel[6 +: LOC_W]);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fbpa_pool_store.sv
// Free list heads and next links of the three pools.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_pool_store
	import fbpa_pkg::*;
#(
	parameter int POOL_SMALL_BLOCKS = DEF_SMALL_BLOCKS,
	parameter int POOL_MID_BLOCKS   = DEF_MID_BLOCKS,
	parameter int POOL_LARGE_BLOCKS = DEF_LARGE_BLOCKS,
	localparam int TOTAL            = POOL_SMALL_BLOCKS + POOL_MID_BLOCKS + POOL_LARGE_BLOCKS,
	localparam int IW               = $clog2(TOTAL + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire upd_t          upd,
	input  wire logic [IW-1:0] push_idx,
	output logic      [IW-1:0] head
);

	localparam int AW          = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int MID_FIRST   = POOL_SMALL_BLOCKS;
	localparam int LARGE_FIRST = POOL_SMALL_BLOCKS + POOL_MID_BLOCKS;
	localparam logic [IW-1:0] NULL_LINK = IW'(TOTAL);

	logic [IW-1:0] head_small_q;
	logic [IW-1:0] head_mid_q;
	logic [IW-1:0] head_large_q;
	logic [IW-1:0] link_q [TOTAL];
	logic [IW-1:0] head_link;

	always_comb begin
		case (upd.pool)
			POOL_SMALL: head = head_small_q;
			POOL_MID:   head = head_mid_q;
			POOL_LARGE: head = head_large_q;
			default:    head = NULL_LINK;
		endcase
	end

	// Only used on a pop, where the head is a valid block.
	assign head_link = link_q[head[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_small_q <= '0;
			head_mid_q   <= IW'(MID_FIRST);
			head_large_q <= IW'(LARGE_FIRST);
		end else if (upd.pop || upd.push) begin
			case (upd.pool)
				POOL_SMALL: head_small_q <= upd.pop ? head_link : push_idx;
				POOL_MID:   head_mid_q   <= upd.pop ? head_link : push_idx;
				POOL_LARGE: head_large_q <= upd.pop ? head_link : push_idx;
				default: ;
			endcase
		end
	end

	// Reset chains each pool's blocks in order, last block of a pool null.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < TOTAL; g++) begin
				if (g == MID_FIRST - 1 || g == LARGE_FIRST - 1 || g == TOTAL - 1) begin
					link_q[g] <= NULL_LINK;
				end else begin
					link_q[g] <= IW'(g + 1);
				end
			end
		end else if (upd.pop) begin
			link_q[head[AW-1:0]] <= NULL_LINK;
		end else if (upd.push) begin
			link_q[push_idx[AW-1:0]] <= head;
		end
	end

endmodule

`default_nettype wire
